>>> rtl/ket_pkg.sv
// Shared types and constants for the keyed table engine.
package ket_pkg;

	// Table geometry.
	localparam int DEPTH  = 64;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int CAP_W  = 7;
	localparam int ECNT_W = 7;

	// Command codes.
	typedef enum logic [1:0] {
		FUNC_ADD = 2'd0,
		FUNC_DEL = 2'd1,
		FUNC_UPD = 2'd2,
		FUNC_GET = 2'd3
	} func_t;

	// Status codes.
	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_FULL       = 3'd1,
		ST_DUP        = 3'd2,
		ST_GET_MISS   = 3'd3,
		ST_DEL_MISS   = 3'd4,
		ST_NEW_EXISTS = 3'd5,
		ST_UPD_MISS   = 3'd6
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_RESOLVE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_FINISH
	} state_t;

	// One command.
	typedef struct packed {
		func_t              func;
		logic signed [31:0] key;
		logic signed [31:0] new_key;
		logic [63:0]        payload;
	} in_t;

	// One result.
	typedef struct packed {
		status_t             status;
		logic signed [31:0]  found_key;
		logic [63:0]         found_payload;
		logic [ECNT_W-1:0]   entry_count;
	} out_t;

	// Write port of the entry store.
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [31:0]       key;
		logic [63:0]       payload;
	} wr_t;

endpackage

>>> rtl/ket_store.sv
// Entry store: key and payload memories with one write and one registered read port.
module ket_store (
	input  logic                       clk,
	input  ket_pkg::wr_t               wr,
	input  logic [ket_pkg::ADDR_W-1:0] rd_addr,
	output logic [31:0]                rd_key_q,
	output logic [63:0]                rd_payload_q
);

	logic [31:0] key_mem [ket_pkg::DEPTH];
	logic [63:0] pay_mem [ket_pkg::DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr.we) begin
			key_mem[wr.addr] <= wr.key;
			pay_mem[wr.addr] <= wr.payload;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rd_key_q     <= key_mem[rd_addr];
		rd_payload_q <= pay_mem[rd_addr];
	end

endmodule

>>> rtl/keyed_table_engine.sv
// Keyed table engine: top level with the command sequencer and control registers.
// A command scans the stored entries, each with a read and then a compare on the single store
// read port; a key hit ends the scan except for update. A delete of slot s scans s+1 entries and
// shifts count-s-1 entries down, each with a read and then a write. No new command is taken
// until the last one has finished; a stall on the out side holds it in the finish state.
// Reset clears the entry count and sets capacity to 64; stored entries are not cleared.
module keyed_table_engine (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  ket_pkg::in_t              in_item,
	output logic                      out_valid,
	input  logic                      out_ready,
	output ket_pkg::out_t             out_item,
	input  logic                      cfg_we,
	input  logic [ket_pkg::CAP_W-1:0] cfg_data
);

	ket_pkg::state_t               state_q, state_d;
	ket_pkg::in_t                  item_q;
	ket_pkg::status_t              status_q, status_d;
	ket_pkg::wr_t                  mem_wr;
	ket_pkg::out_t                 out_q;
	logic [ket_pkg::CAP_W-1:0]     cap_q;
	logic [ket_pkg::CNT_W-1:0]     count_q;
	logic [ket_pkg::CNT_W-1:0]     ptr_q;
	logic [ket_pkg::CNT_W-1:0]     slot_q;
	logic [ket_pkg::CNT_W-1:0]     ptr_inc;
	logic [ket_pkg::CNT_W-1:0]     ptr_inc2;
	logic [ket_pkg::ADDR_W-1:0]    rd_addr;
	logic [31:0]                   rd_key;
	logic [63:0]                   rd_payload;
	logic [31:0]                   found_key_q;
	logic [63:0]                   found_payload_q;
	logic                          hit_q, nk_hit_q;
	logic                          out_valid_q;
	logic                          key_match, nk_match, scan_last, shift_last;
	logic                          table_full, out_free;

	ket_store u_store (
		.clk          (clk),
		.wr           (mem_wr),
		.rd_addr      (rd_addr),
		.rd_key_q     (rd_key),
		.rd_payload_q (rd_payload)
	);

	// Scan and shift helpers.
	assign ptr_inc    = ptr_q + ket_pkg::CNT_W'(1);
	assign ptr_inc2   = ptr_q + ket_pkg::CNT_W'(2);
	assign key_match  = (rd_key == item_q.key);
	assign nk_match   = (rd_key == item_q.new_key);
	assign scan_last  = (ptr_inc >= count_q) || (key_match && item_q.func != ket_pkg::FUNC_UPD);
	assign shift_last = (ptr_inc2 >= count_q);
	assign rd_addr    = (state_q == ket_pkg::S_SHIFT_RD) ? ptr_inc[ket_pkg::ADDR_W-1:0]
	                                                     : ptr_q[ket_pkg::ADDR_W-1:0];
	assign table_full = (32'(count_q) >= 32'(cap_q)) || (32'(count_q) >= ket_pkg::DEPTH);
	assign out_free   = !out_valid_q || out_ready;

	// Next state, store writes and status.
	always_comb begin
		state_d  = state_q;
		status_d = status_q;
		in_ready = 1'b0;
		mem_wr   = '0;
		unique case (state_q)
			ket_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = (count_q == '0) ? ket_pkg::S_RESOLVE : ket_pkg::S_SCAN_RD;
				end
			end
			ket_pkg::S_SCAN_RD: begin
				state_d = ket_pkg::S_SCAN_CMP;
			end
			ket_pkg::S_SCAN_CMP: begin
				state_d = scan_last ? ket_pkg::S_RESOLVE : ket_pkg::S_SCAN_RD;
			end
			ket_pkg::S_RESOLVE: begin
				state_d  = ket_pkg::S_FINISH;
				status_d = ket_pkg::ST_OK;
				unique case (item_q.func)
					ket_pkg::FUNC_ADD: begin
						if (table_full) begin
							status_d = ket_pkg::ST_FULL;
						end else if (hit_q) begin
							status_d = ket_pkg::ST_DUP;
						end else begin
							mem_wr.we      = 1'b1;
							mem_wr.addr    = count_q[ket_pkg::ADDR_W-1:0];
							mem_wr.key     = item_q.key;
							mem_wr.payload = item_q.payload;
						end
					end
					ket_pkg::FUNC_DEL: begin
						if (!hit_q) begin
							status_d = ket_pkg::ST_DEL_MISS;
						end else if (slot_q + ket_pkg::CNT_W'(1) < count_q) begin
							state_d = ket_pkg::S_SHIFT_RD;
						end
					end
					ket_pkg::FUNC_UPD: begin
						if (nk_hit_q) begin
							status_d = ket_pkg::ST_NEW_EXISTS;
						end else if (!hit_q) begin
							status_d = ket_pkg::ST_UPD_MISS;
						end else begin
							mem_wr.we      = 1'b1;
							mem_wr.addr    = slot_q[ket_pkg::ADDR_W-1:0];
							mem_wr.key     = item_q.new_key;
							mem_wr.payload = item_q.payload;
						end
					end
					ket_pkg::FUNC_GET: begin
						if (!hit_q) begin
							status_d = ket_pkg::ST_GET_MISS;
						end
					end
					default: begin
						status_d = ket_pkg::ST_OK;
					end
				endcase
			end
			ket_pkg::S_SHIFT_RD: begin
				state_d = ket_pkg::S_SHIFT_WR;
			end
			ket_pkg::S_SHIFT_WR: begin
				mem_wr.we      = 1'b1;
				mem_wr.addr    = ptr_q[ket_pkg::ADDR_W-1:0];
				mem_wr.key     = rd_key;
				mem_wr.payload = rd_payload;
				state_d        = shift_last ? ket_pkg::S_FINISH : ket_pkg::S_SHIFT_RD;
			end
			ket_pkg::S_FINISH: begin
				if (out_free) begin
					state_d = ket_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ket_pkg::S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ket_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= ket_pkg::CAP_W'(64);
		end else if (cfg_we) begin
			cap_q <= cfg_data;
		end
	end

	// Entry count: grows on a successful add, shrinks at the end of a delete.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (state_q == ket_pkg::S_RESOLVE) begin
			if (item_q.func == ket_pkg::FUNC_ADD && !table_full && !hit_q) begin
				count_q <= count_q + ket_pkg::CNT_W'(1);
			end else if (item_q.func == ket_pkg::FUNC_DEL && hit_q
			             && !(slot_q + ket_pkg::CNT_W'(1) < count_q)) begin
				count_q <= count_q - ket_pkg::CNT_W'(1);
			end
		end else if (state_q == ket_pkg::S_SHIFT_WR && shift_last) begin
			count_q <= count_q - ket_pkg::CNT_W'(1);
		end
	end

	// Scan pointer and match results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q    <= 1'b0;
			nk_hit_q <= 1'b0;
			ptr_q    <= '0;
		end else begin
			unique case (state_q)
				ket_pkg::S_IDLE: begin
					if (in_valid) begin
						hit_q    <= 1'b0;
						nk_hit_q <= 1'b0;
						ptr_q    <= '0;
					end
				end
				ket_pkg::S_SCAN_CMP: begin
					ptr_q <= ptr_inc;
					if (key_match) begin
						hit_q <= 1'b1;
					end
					if (nk_match) begin
						nk_hit_q <= 1'b1;
					end
				end
				ket_pkg::S_RESOLVE: begin
					ptr_q <= slot_q;
				end
				ket_pkg::S_SHIFT_WR: begin
					ptr_q <= ptr_inc;
				end
				default: begin
					ptr_q <= ptr_q;
				end
			endcase
		end
	end

	// Payload registers of the command in work.
	always_ff @(posedge clk) begin
		if (state_q == ket_pkg::S_IDLE && in_valid) begin
			item_q          <= in_item;
			found_key_q     <= '0;
			found_payload_q <= '0;
			slot_q          <= '0;
		end else if (state_q == ket_pkg::S_SCAN_CMP && key_match && !hit_q) begin
			slot_q          <= ptr_q;
			found_key_q     <= rd_key;
			found_payload_q <= rd_payload;
		end
		status_q <= status_d;
	end

	// Output register: a finished transaction waits here while the next command is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ket_pkg::S_FINISH && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ket_pkg::S_FINISH && out_free) begin
			out_q.status      <= status_q;
			out_q.entry_count <= ket_pkg::ECNT_W'(count_q);
			if (item_q.func == ket_pkg::FUNC_GET && hit_q) begin
				out_q.found_key     <= found_key_q;
				out_q.found_payload <= found_payload_q;
			end else begin
				out_q.found_key     <= '0;
				out_q.found_payload <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

>>> verif/keyed_table_engine_tb.sv
// Self-checking testbench for the keyed table engine: directed plan, then random phases.
module keyed_table_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT     = 3_000_000;
	localparam int DRAIN_CYCLES    = 300;
	localparam int KEY_POOL        = 96;
	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 210;
	// A negative capacity entry means a random capacity for that phase.
	localparam int PHASE_CAP [NUM_PHASES]     = '{64, 5, 1, 64, -1, 127, 2, 64};
	localparam int PHASE_ADD_PCT [NUM_PHASES] = '{75, 30, 35, 60, 45, 55, 40, 45};

	typedef enum {READY_ALWAYS, READY_COIN, READY_EVERY_N} ready_mode_t;

	// One row of the directed plan: a capacity write or a command.
	typedef struct {
		bit            is_cfg;
		logic [6:0]    cap;
		ket_pkg::in_t  cmd;
		bit            typed;
		ket_pkg::out_t want;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	ket_pkg::in_t in_item;
	logic out_valid;
	logic out_ready;
	ket_pkg::out_t out_item;
	logic cfg_we;
	logic [ket_pkg::CAP_W-1:0] cfg_data;

	// Shadow copy of the table contents and the capacity register.
	logic [31:0] tbl_key [ket_pkg::DEPTH];
	logic [63:0] tbl_pay [ket_pkg::DEPTH];
	int tbl_count;
	logic [6:0] tbl_cap;

	ket_pkg::out_t pending_results [$];
	plan_row_t plan [$];
	logic [31:0] key_pool [KEY_POOL];
	int mismatches = 0;
	int cycles = 0;
	int burst_left;

	keyed_table_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("keyed_table_engine_tb NOT OK");
			$finish;
		end
	end

	// Returns the slot holding k, or the entry count when no slot holds it.
	function automatic int find_entry(input logic [31:0] k);
		for (int s = 0; s < tbl_count; s++) begin
			if (tbl_key[s] == k)
				return s;
		end
		return tbl_count;
	endfunction

	// Applies one command to the shadow table and returns the result it should give.
	function automatic ket_pkg::out_t apply_command(input ket_pkg::in_t c);
		ket_pkg::out_t r;
		int s;
		int lim;
		r = '0;
		r.status = ket_pkg::ST_OK;
		lim = (tbl_cap > ket_pkg::DEPTH) ? ket_pkg::DEPTH : int'(tbl_cap);
		case (c.func)
			ket_pkg::FUNC_ADD: begin
				if (tbl_count >= lim) begin
					r.status = ket_pkg::ST_FULL;
				end else if (find_entry(c.key) < tbl_count) begin
					r.status = ket_pkg::ST_DUP;
				end else begin
					tbl_key[tbl_count] = c.key;
					tbl_pay[tbl_count] = c.payload;
					tbl_count++;
				end
			end
			ket_pkg::FUNC_DEL: begin
				s = find_entry(c.key);
				if (s >= tbl_count) begin
					r.status = ket_pkg::ST_DEL_MISS;
				end else begin
					for (int j = s; j + 1 < tbl_count; j++) begin
						tbl_key[j] = tbl_key[j + 1];
						tbl_pay[j] = tbl_pay[j + 1];
					end
					tbl_count--;
				end
			end
			ket_pkg::FUNC_UPD: begin
				// The new key is checked before the old key is searched.
				if (find_entry(c.new_key) < tbl_count) begin
					r.status = ket_pkg::ST_NEW_EXISTS;
				end else begin
					s = find_entry(c.key);
					if (s >= tbl_count) begin
						r.status = ket_pkg::ST_UPD_MISS;
					end else begin
						tbl_key[s] = c.new_key;
						tbl_pay[s] = c.payload;
					end
				end
			end
			default: begin
				s = find_entry(c.key);
				if (s >= tbl_count) begin
					r.status = ket_pkg::ST_GET_MISS;
				end else begin
					r.found_key = tbl_key[s];
					r.found_payload = tbl_pay[s];
				end
			end
		endcase
		r.entry_count = ket_pkg::ECNT_W'(tbl_count);
		return r;
	endfunction

	// Picks a key held in the table, from the shared pool, or fully random.
	function automatic logic [31:0] pick_key(input int hit_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < hit_pct && tbl_count > 0)
			return tbl_key[$urandom_range(0, tbl_count - 1)];
		if (r < 90)
			return key_pool[$urandom_range(0, KEY_POOL - 1)];
		return $urandom;
	endfunction

	function automatic ket_pkg::in_t random_command(input int add_pct);
		ket_pkg::in_t c;
		c.payload = {$urandom, $urandom};
		c.new_key = pick_key(25);
		if ($urandom_range(0, 99) < add_pct) begin
			c.func = ket_pkg::FUNC_ADD;
			c.key = pick_key(20);
		end else begin
			case ($urandom_range(0, 2))
				0: c.func = ket_pkg::FUNC_DEL;
				1: c.func = ket_pkg::FUNC_UPD;
				default: c.func = ket_pkg::FUNC_GET;
			endcase
			c.key = pick_key(60);
		end
		return c;
	endfunction

	// Directed plan rows: checked against a typed result, checked by the shadow table,
	// or a capacity write.
	function automatic void plan_chk(input ket_pkg::func_t f, input logic [31:0] k,
			input logic [31:0] nk, input logic [63:0] p, input ket_pkg::status_t st,
			input logic [31:0] fk, input logic [63:0] fp, input int n);
		plan_row_t row;
		row.is_cfg = 1'b0;
		row.cap = '0;
		row.cmd.func = f;
		row.cmd.key = k;
		row.cmd.new_key = nk;
		row.cmd.payload = p;
		row.typed = 1'b1;
		row.want.status = st;
		row.want.found_key = fk;
		row.want.found_payload = fp;
		row.want.entry_count = ket_pkg::ECNT_W'(n);
		plan.push_back(row);
	endfunction

	function automatic void plan_cmd(input ket_pkg::func_t f, input logic [31:0] k,
			input logic [31:0] nk, input logic [63:0] p);
		plan_row_t row;
		row.is_cfg = 1'b0;
		row.cap = '0;
		row.cmd.func = f;
		row.cmd.key = k;
		row.cmd.new_key = nk;
		row.cmd.payload = p;
		row.typed = 1'b0;
		row.want = '0;
		plan.push_back(row);
	endfunction

	function automatic void plan_cap(input logic [6:0] v);
		plan_row_t row;
		row.is_cfg = 1'b1;
		row.cap = v;
		row.cmd = '0;
		row.typed = 1'b0;
		row.want = '0;
		plan.push_back(row);
	endfunction

	// Stops sending and waits until every outstanding result has arrived.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Writes the capacity register; the block must be idle.
	task automatic write_capacity(input logic [6:0] v);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		tbl_cap = v;
	endtask

	// Sends one command transaction, records its expected result, then paces the sender.
	task automatic issue(input ket_pkg::in_t c, input bit typed,
			input ket_pkg::out_t typed_want);
		ket_pkg::out_t predicted;
		in_item <= c;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		predicted = apply_command(c);
		pending_results.push_back(typed ? typed_want : predicted);
		if ($urandom_range(0, 299) == 0) begin
			// Occasionally let the block drain completely before going on.
			settle();
		end else if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 250)
				: $urandom_range(0, 30);
		end
	endtask

	// Receiver: out_ready follows a random stall pattern, chosen anew for each span of random length.
	initial begin
		ready_mode_t mode;
		int span;
		int n;
		out_ready = 1'b0;
		forever begin
			mode = ready_mode_t'($urandom_range(0, 2));
			span = $urandom_range(50, 400);
			n = $urandom_range(2, 6);
			for (int k = 0; k < span; k++) begin
				@(posedge clk);
				case (mode)
					READY_ALWAYS: out_ready <= 1'b1;
					READY_COIN: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= (k % n == 0);
				endcase
			end
		end
	end

	// Result checker: each result transaction is matched against the oldest expectation.
	always @(posedge clk) begin
		ket_pkg::out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with no command outstanding");
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (out_item.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, out_item.status);
					mismatches++;
				end
				if (out_item.found_key !== want.found_key) begin
					$error("found_key: expected %h, actual %h", want.found_key,
						out_item.found_key);
					mismatches++;
				end
				if (out_item.found_payload !== want.found_payload) begin
					$error("found_payload: expected %h, actual %h", want.found_payload,
						out_item.found_payload);
					mismatches++;
				end
				if (out_item.entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, actual %0d", want.entry_count,
						out_item.entry_count);
					mismatches++;
				end
			end
		end
	end

	// Main sequence: reset, directed plan, random phases, drain and verdict.
	initial begin
		int cap;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		tbl_count = 0;
		tbl_cap = 7'd64;
		burst_left = 0;

		// Key pool starts with the signed extremes, zero and minus one.
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hFFFF_FFFF;
		for (int i = 4; i < KEY_POOL; i++)
			key_pool[i] = $urandom;

		// Empty table, extreme keys and payloads, update corner cases.
		plan_chk(ket_pkg::FUNC_GET, 0, 0, 64'h0, ket_pkg::ST_GET_MISS, 0, 0, 0);
		plan_chk(ket_pkg::FUNC_DEL, 0, 0, 64'h0, ket_pkg::ST_DEL_MISS, 0, 0, 0);
		plan_chk(ket_pkg::FUNC_UPD, 5, 6, 64'h1, ket_pkg::ST_UPD_MISS, 0, 0, 0);
		plan_chk(ket_pkg::FUNC_ADD, 32'h8000_0000, 0, 64'h0, ket_pkg::ST_OK, 0, 0, 1);
		plan_chk(ket_pkg::FUNC_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
			ket_pkg::ST_OK, 0, 0, 2);
		plan_chk(ket_pkg::FUNC_ADD, 32'h8000_0000, 0, 64'h1, ket_pkg::ST_DUP, 0, 0, 2);
		plan_chk(ket_pkg::FUNC_GET, 32'h7FFF_FFFF, 32'h1234_5678, 64'hDEAD_BEEF,
			ket_pkg::ST_OK, 32'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 2);
		plan_chk(ket_pkg::FUNC_UPD, 32'h8000_0000, 32'h8000_0000, 64'h2,
			ket_pkg::ST_NEW_EXISTS, 0, 0, 2);
		plan_chk(ket_pkg::FUNC_UPD, 32'h8000_0000, 32'h7FFF_FFFF, 64'h3,
			ket_pkg::ST_NEW_EXISTS, 0, 0, 2);
		plan_chk(ket_pkg::FUNC_UPD, 32'h8000_0000, 0, 64'hA5A5_A5A5_A5A5_A5A5,
			ket_pkg::ST_OK, 0, 0, 2);
		plan_chk(ket_pkg::FUNC_GET, 0, 0, 64'h0, ket_pkg::ST_OK, 0,
			64'hA5A5_A5A5_A5A5_A5A5, 2);
		plan_chk(ket_pkg::FUNC_GET, 32'h8000_0000, 0, 64'h0, ket_pkg::ST_GET_MISS, 0, 0, 2);
		plan_chk(ket_pkg::FUNC_ADD, 32'hFFFF_FFFF, 0, 64'h0123_4567_89AB_CDEF,
			ket_pkg::ST_OK, 0, 0, 3);
		plan_cmd(ket_pkg::FUNC_ADD, 1, 0, 64'h5A5A_0F0F_F0F0_5A5A);
		// Deleting the first slot shifts every later entry down.
		plan_chk(ket_pkg::FUNC_DEL, 0, 0, 64'h0, ket_pkg::ST_OK, 0, 0, 3);
		plan_cmd(ket_pkg::FUNC_GET, 1, 0, 64'h0);
		// Capacity lowered below the count: adds are full, the full check wins over duplicate.
		plan_cap(7'd2);
		plan_chk(ket_pkg::FUNC_ADD, 2, 0, 64'h0, ket_pkg::ST_FULL, 0, 0, 3);
		plan_chk(ket_pkg::FUNC_ADD, 1, 0, 64'h0, ket_pkg::ST_FULL, 0, 0, 3);
		plan_cmd(ket_pkg::FUNC_UPD, 1, 3, 64'hC3C3_3C3C_C3C3_3C3C);
		plan_chk(ket_pkg::FUNC_DEL, 3, 0, 64'h0, ket_pkg::ST_OK, 0, 0, 2);
		plan_chk(ket_pkg::FUNC_ADD, 1, 0, 64'h0, ket_pkg::ST_FULL, 0, 0, 2);
		// A capacity of zero refuses every add; one above the depth is clamped.
		plan_cap(7'd0);
		plan_chk(ket_pkg::FUNC_DEL, 32'h7FFF_FFFF, 0, 64'h0, ket_pkg::ST_OK, 0, 0, 1);
		plan_chk(ket_pkg::FUNC_ADD, 9, 0, 64'h0, ket_pkg::ST_FULL, 0, 0, 1);
		plan_cap(7'd127);
		plan_chk(ket_pkg::FUNC_ADD, 9, 0, 64'h0, ket_pkg::ST_OK, 0, 0, 2);
		plan_cmd(ket_pkg::FUNC_GET, 32'hFFFF_FFFF, 0, 64'h0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				settle();
				write_capacity(plan[i].cap);
			end else begin
				issue(plan[i].cmd, plan[i].typed, plan[i].want);
			end
		end

		// Random phases, each under its own capacity and command mix.
		for (int p = 0; p < NUM_PHASES; p++) begin
			cap = PHASE_CAP[p];
			if (cap < 0)
				cap = $urandom_range(1, ket_pkg::DEPTH);
			settle();
			write_capacity(7'(cap));
			repeat (ITEMS_PER_PHASE)
				issue(random_command(PHASE_ADD_PCT[p]), 1'b0, '0);
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d expected results never arrived", pending_results.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("keyed_table_engine_tb OK");
		end else begin
			$display("keyed_table_engine_tb NOT OK");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/ket_pkg.sv
rtl/ket_store.sv
rtl/keyed_table_engine.sv
verif/keyed_table_engine_tb.sv
